/* rtl/core/cve_pkg.sv */
// ----------------------------------------------------------------------------
// cve_pkg
// Shared types, codes and saturation helpers for the channel vocoder engine.
// ----------------------------------------------------------------------------
package cve_pkg;

  // Default number of filter bands.
  localparam int BANDS_DEF = 32;
  // Coefficient entries stored per band.
  localparam int NSEL = 10;

  // Operation codes of an input word.
  localparam logic [1:0] OP_AUDIO = 2'd0;
  localparam logic [1:0] OP_COEF  = 2'd1;
  localparam logic [1:0] OP_ROUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BYPASS = 2'd0;
  localparam logic [1:0] CFG_CGAIN  = 2'd1;
  localparam logic [1:0] CFG_MGAIN  = 2'd2;

  // Coefficient selectors within a band.
  localparam logic [3:0] SEL_CA1     = 4'd0;
  localparam logic [3:0] SEL_CA2     = 4'd1;
  localparam logic [3:0] SEL_CB      = 4'd2;
  localparam logic [3:0] SEL_MA1     = 4'd3;
  localparam logic [3:0] SEL_MA2     = 4'd4;
  localparam logic [3:0] SEL_MB      = 4'd5;
  localparam logic [3:0] SEL_ATTACK  = 4'd6;
  localparam logic [3:0] SEL_RELEASE = 4'd7;
  localparam logic [3:0] SEL_LEFT    = 4'd8;
  localparam logic [3:0] SEL_RIGHT   = 4'd9;

  // Configuration registers as seen by the core.
  typedef struct packed {
    logic        bypass;
    logic [15:0] carrier_gain;
    logic [15:0] modulator_gain;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [23:0] carrier_sample;
    logic signed [23:0] modulator_sample;
    logic [4:0]         band;
    logic [3:0]         coef_select;
    logic signed [23:0] coef_value;
    logic [31:0]        route_mask;
  } item_t;

  // Finished result handed from the core to the output register.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] left;
    logic signed [31:0] right;
  } res_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (&v[71:31] || ~|v[71:31]) begin
      r = v[31:0];
    end else if (v[71]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Saturate a gained sample to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (&v[27:23] || ~|v[27:23]) begin
      r = v[23:0];
    end else if (v[27]) begin
      r = 24'sh80_0000;
    end else begin
      r = 24'sh7F_FFFF;
    end
    return r;
  endfunction

endpackage

/* rtl/core/channel_vocoder_engine.sv */
// ----------------------------------------------------------------------------
// channel_vocoder_engine
// Stereo channel vocoder: gain, two biquad banks, envelope followers and a
// routed mix, all computed on one shared multiplier.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake          | word
//   in_      | input     | in_valid/in_stall   | audio sample or table write
//   out_     | output    | out_valid/out_stall | left and right sample
//   cfg_     | input     | cfg_wr_en           | bypass and gain registers
//
// An audio word runs gain, filter and envelope steps for every band, then the
// routed mix over every routing row when not in bypass; every product passes
// through the single shared multiplier.
// Reset is synchronous and clears all filter, envelope and routing state.
// The next word is taken once the result has moved to the output register.
// ----------------------------------------------------------------------------
module channel_vocoder_engine #(
  parameter int BANDS = cve_pkg::BANDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [23:0] in_carrier_sample,
  input  logic signed [23:0] in_modulator_sample,
  input  logic [4:0]         in_band,
  input  logic [3:0]         in_coef_select,
  input  logic signed [23:0] in_coef_value,
  input  logic [31:0]        in_route_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_left_out,
  output logic signed [31:0] out_right_out,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cve_pkg::cfg_t  cfg_r;
  cve_pkg::item_t item;
  cve_pkg::res_t  res;
  logic           busy, out_ready;
  logic           out_valid_r;
  logic signed [31:0] left_r, right_r;

  assign item.operation        = in_operation;
  assign item.carrier_sample   = in_carrier_sample;
  assign item.modulator_sample = in_modulator_sample;
  assign item.band             = in_band;
  assign item.coef_select      = in_coef_select;
  assign item.coef_value       = in_coef_value;
  assign item.route_mask       = in_route_mask;

  assign in_stall  = busy;
  assign out_ready = !out_valid_r || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass         <= 1'b0;
      cfg_r.carrier_gain   <= 16'd4096;
      cfg_r.modulator_gain <= 16'd4096;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cve_pkg::CFG_BYPASS: cfg_r.bypass         <= cfg_data[0];
        cve_pkg::CFG_CGAIN:  cfg_r.carrier_gain   <= cfg_data;
        cve_pkg::CFG_MGAIN:  cfg_r.modulator_gain <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register between the core and the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res.valid) begin
      left_r  <= res.left;
      right_r <= res.right;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = left_r;
  assign out_right_out = right_r;

  cve_core #(
    .BANDS (BANDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .item      (item),
    .busy      (busy),
    .out_ready (out_ready),
    .res       (res)
  );

endmodule

/* rtl/core/cve_mul.sv */
// ----------------------------------------------------------------------------
// cve_mul
// Shared signed 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module cve_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] prod_r
);

  // The product is registered: it is ready in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

/* rtl/core/cve_coef_ram.sv */
// ----------------------------------------------------------------------------
// cve_coef_ram
// Coefficient memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cve_coef_ram #(
  parameter int DEPTH = 320,
  parameter int AW    = 9
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [23:0]   wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [23:0]   rdata_r
);

  logic signed [23:0] mem [DEPTH];

  // Write and read are both synchronous.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* rtl/core/cve_core.sv */
// ----------------------------------------------------------------------------
// cve_core
// Sequencer and band state. All products go through one shared multiplier.
// ----------------------------------------------------------------------------
module cve_core #(
  parameter int BANDS = cve_pkg::BANDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cve_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  cve_pkg::item_t item,
  output logic           busy,
  input  logic           out_ready,
  output cve_pkg::res_t  res
);

  localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int DEPTH = BANDS * cve_pkg::NSEL;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [BW-1:0] LAST = BW'(BANDS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_G0, S_G1, S_G2, S_FETCH,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_B5,
    S_F0, S_F1, S_F2, S_F3,
    S_MFETCH, S_SCAN, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_DONE
  } state_t;

  state_t state_r;

  logic [BW-1:0] i_r, j_r;
  logic          sd_r;
  logic [3:0]    k_r;
  logic          rd_pend_r;
  logic [3:0]    rd_sel_r;

  logic signed [23:0] creg_r [cve_pkg::NSEL];
  logic signed [23:0] samp_c_r, samp_m_r;
  logic signed [27:0] gc_r, gm_r;
  logic signed [23:0] xc_r, xm_r, hc0_r, hc1_r, hm0_r, hm1_r;
  logic signed [31:0] cy1_r [BANDS];
  logic signed [31:0] cy2_r [BANDS];
  logic signed [31:0] my1_r [BANDS];
  logic signed [31:0] my2_r [BANDS];
  logic signed [31:0] env_r [BANDS];
  logic [31:0]        route_r [BANDS];

  logic signed [37:0] t_r;
  logic [31:0]        r_r;
  logic signed [23:0] f_r;
  logic signed [65:0] lo_r;
  logic signed [41:0] p_r;
  logic signed [63:0] term_r, accl_r, accr_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_r;
  logic [AW-1:0]      raddr, waddr;
  logic signed [23:0] rdata_r;
  logic               we;

  logic               accept, band_ok;
  logic signed [23:0] a1_w, a2_w, b_w, x0_w, x2_w;
  logic signed [31:0] y1_w, y2_w, ym_w, yq_w;
  logic signed [71:0] split_w, pair_w;
  logic [31:0]        rabs_w;
  logic [AW-1:0]      base_w;

  assign busy    = (state_r != S_IDLE);
  assign accept  = in_valid && (state_r == S_IDLE);
  assign band_ok = ({1'b0, item.band} < 6'(BANDS));

  // Coefficient base address of the current band: i * 10.
  assign base_w = (AW'(i_r) << 3) + (AW'(i_r) << 1);

  // Coefficient writes go straight into the memory.
  assign we    = accept && (item.operation == cve_pkg::OP_COEF) && band_ok &&
                 (item.coef_select < 4'(cve_pkg::NSEL));
  assign waddr = (AW'(item.band[BW-1:0]) << 3) + (AW'(item.band[BW-1:0]) << 1) +
                 AW'(item.coef_select);

  // Read address: sequential fetch of the current band's coefficients.
  always_comb begin
    if (state_r == S_MFETCH) begin
      raddr = base_w + AW'(cve_pkg::SEL_LEFT) + AW'(k_r);
    end else begin
      raddr = base_w + AW'(k_r);
    end
  end

  // Operands of the side in work (carrier or modulator).
  assign a1_w = sd_r ? creg_r[cve_pkg::SEL_MA1] : creg_r[cve_pkg::SEL_CA1];
  assign a2_w = sd_r ? creg_r[cve_pkg::SEL_MA2] : creg_r[cve_pkg::SEL_CA2];
  assign b_w  = sd_r ? creg_r[cve_pkg::SEL_MB]  : creg_r[cve_pkg::SEL_CB];
  assign x0_w = sd_r ? xm_r  : xc_r;
  assign x2_w = sd_r ? hm1_r : hc1_r;
  assign y1_w = sd_r ? my1_r[i_r] : cy1_r[i_r];
  assign y2_w = sd_r ? my2_r[i_r] : cy2_r[i_r];

  // Recombine a product split into low and high partial products.
  assign split_w = 72'(lo_r) + (72'(prod_r) <<< 32);
  assign pair_w  = 72'(lo_r) + 72'(prod_r);
  assign yq_w    = cve_pkg::sat32(split_w >>> 21);

  // Rectified modulator band output, saturated to 2^31-1.
  assign ym_w = my1_r[i_r];
  always_comb begin
    if (ym_w == 32'sh8000_0000) begin
      rabs_w = 32'h7FFF_FFFF;
    end else if (ym_w[31]) begin
      rabs_w = 32'(-ym_w);
    end else begin
      rabs_w = 32'(ym_w);
    end
  end

  // Multiplier operand selection per step.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      S_G0: begin
        ma = 33'(samp_c_r);
        mb = $signed({17'b0, cfg.carrier_gain});
      end
      S_G1: begin
        ma = 33'(samp_m_r);
        mb = $signed({17'b0, cfg.modulator_gain});
      end
      S_B0: begin
        ma = 33'(a2_w);
        mb = 33'(y1_w);
      end
      S_B1: begin
        ma = 33'(b_w);
        mb = 33'(y2_w);
      end
      S_B3: begin
        ma = 33'(a1_w);
        mb = $signed({1'b0, t_r[31:0]});
      end
      S_B4: begin
        ma = 33'(a1_w);
        mb = 33'(t_r >>> 32);
      end
      S_F1: begin
        ma = 33'sd2097152 - 33'(f_r);
        mb = $signed({1'b0, r_r});
      end
      S_F2: begin
        ma = 33'(f_r);
        mb = 33'(env_r[i_r]);
      end
      S_SCAN: begin
        ma = 33'(cy1_r[j_r]);
        mb = 33'(env_r[i_r]);
      end
      S_M2, S_M4: begin
        ma = (state_r == S_M2) ? 33'(creg_r[cve_pkg::SEL_LEFT])
                               : 33'(creg_r[cve_pkg::SEL_RIGHT]);
        mb = $signed({1'b0, p_r[31:0]});
      end
      S_M3, S_M5: begin
        ma = (state_r == S_M3) ? 33'(creg_r[cve_pkg::SEL_LEFT])
                               : 33'(creg_r[cve_pkg::SEL_RIGHT]);
        mb = 33'(p_r >>> 32);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Result of the finished item.
  always_comb begin
    res.valid = (state_r == S_DONE);
    if (cfg.bypass) begin
      res.left  = 32'(gc_r);
      res.right = 32'(gm_r);
    end else begin
      res.left  = cve_pkg::sat32(72'(accl_r));
      res.right = cve_pkg::sat32(72'(accr_r));
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      creg_r[rd_sel_r] <= rdata_r;
    end
    if (accept) begin
      samp_c_r <= item.carrier_sample;
      samp_m_r <= item.modulator_sample;
    end
    unique case (state_r)
      S_G1: begin
        gc_r <= 28'(prod_r >>> 12);
        xc_r <= cve_pkg::sat24(28'(prod_r >>> 12));
      end
      S_G2: begin
        gm_r <= 28'(prod_r >>> 12);
        xm_r <= cve_pkg::sat24(28'(prod_r >>> 12));
      end
      S_B1: t_r <= 38'(x0_w) - 38'(x2_w) - 38'(prod_r >>> 21);
      S_B2: t_r <= t_r - 38'(prod_r >>> 21);
      S_B4, S_F2, S_M3, S_M5: lo_r <= prod_r;
      S_F0: begin
        r_r <= rabs_w;
        f_r <= (33'(env_r[i_r]) < $signed({1'b0, rabs_w})) ?
               creg_r[cve_pkg::SEL_ATTACK] : creg_r[cve_pkg::SEL_RELEASE];
      end
      S_M1: p_r <= 42'(prod_r >>> 23);
      S_M4, S_M6: term_r <= 64'(split_w >>> 21);
      default: begin
      end
    endcase
  end

  // Sequencer and state that resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      sd_r      <= 1'b0;
      k_r       <= '0;
      rd_pend_r <= 1'b0;
      rd_sel_r  <= '0;
      hc0_r     <= '0;
      hc1_r     <= '0;
      hm0_r     <= '0;
      hm1_r     <= '0;
      accl_r    <= '0;
      accr_r    <= '0;
      for (int n = 0; n < BANDS; n++) begin
        cy1_r[n]   <= '0;
        cy2_r[n]   <= '0;
        my1_r[n]   <= '0;
        my2_r[n]   <= '0;
        env_r[n]   <= '0;
        route_r[n] <= '0;
      end
    end else begin
      rd_pend_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (item.operation == cve_pkg::OP_AUDIO) begin
              state_r <= S_G0;
              accl_r  <= '0;
              accr_r  <= '0;
            end else if (item.operation == cve_pkg::OP_ROUTE && band_ok) begin
              route_r[item.band[BW-1:0]] <= item.route_mask;
            end
          end
        end
        S_G0: state_r <= S_G1;
        S_G1: state_r <= S_G2;
        S_G2: begin
          i_r     <= '0;
          k_r     <= '0;
          sd_r    <= 1'b0;
          state_r <= S_FETCH;
        end
        // Read attack/release and both filters' coefficients of band i.
        S_FETCH: begin
          rd_pend_r <= 1'b1;
          rd_sel_r  <= k_r;
          if (k_r == cve_pkg::SEL_RELEASE) begin
            k_r     <= '0;
            state_r <= S_B0;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_B0: state_r <= S_B1;
        S_B1: state_r <= S_B2;
        S_B2: state_r <= S_B3;
        S_B3: state_r <= S_B4;
        S_B4: state_r <= S_B5;
        // Filter output ready: shift the taps.
        S_B5: begin
          if (sd_r) begin
            my2_r[i_r] <= my1_r[i_r];
            my1_r[i_r] <= yq_w;
            sd_r       <= 1'b0;
            state_r    <= S_F0;
          end else begin
            cy2_r[i_r] <= cy1_r[i_r];
            cy1_r[i_r] <= yq_w;
            sd_r       <= 1'b1;
            state_r    <= S_B0;
          end
        end
        S_F0: state_r <= S_F1;
        S_F1: state_r <= S_F2;
        S_F2: state_r <= S_F3;
        // Envelope update and move to the next band.
        S_F3: begin
          env_r[i_r] <= cve_pkg::sat32(pair_w >>> 21);
          if (i_r == LAST) begin
            hc1_r <= hc0_r;
            hc0_r <= xc_r;
            hm1_r <= hm0_r;
            hm0_r <= xm_r;
            i_r   <= '0;
            if (cfg.bypass) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_MFETCH;
            end
          end else begin
            i_r     <= i_r + BW'(1);
            state_r <= S_FETCH;
          end
        end
        // Read the left and right levels of row i.
        S_MFETCH: begin
          rd_pend_r <= 1'b1;
          rd_sel_r  <= cve_pkg::SEL_LEFT + k_r;
          if (k_r == 4'd1) begin
            k_r     <= '0;
            j_r     <= '0;
            state_r <= S_SCAN;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        // Walk the routing row; a set bit starts a pair.
        S_SCAN, S_M7: begin
          if (state_r == S_M7) begin
            accr_r <= accr_r + term_r;
          end
          if (state_r == S_SCAN && route_r[i_r][j_r]) begin
            state_r <= S_M1;
          end else if (j_r == LAST) begin
            j_r <= '0;
            if (i_r == LAST) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + BW'(1);
              state_r <= S_MFETCH;
            end
          end else begin
            j_r     <= j_r + BW'(1);
            state_r <= S_SCAN;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: state_r <= S_M3;
        S_M3: state_r <= S_M4;
        S_M4: state_r <= S_M5;
        S_M5: begin
          accl_r  <= accl_r + term_r;
          state_r <= S_M6;
        end
        S_M6: state_r <= S_M7;
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  cve_mul u_mul (
    .clk    (clk),
    .a      (ma),
    .b      (mb),
    .prod_r (prod_r)
  );

  cve_coef_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (item.coef_value),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

endmodule

/* rtl/core/cve_checker.sv */
// ----------------------------------------------------------------------------
// cve_checker
// Port-level checks of the channel vocoder engine, bound to the top level.
// ----------------------------------------------------------------------------
module cve_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_operation,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_left_out,
  input logic signed [31:0] out_right_out
);

  // A stalled result word stays valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_out) && $stable(out_right_out))
    else $error("result payload changed while stalled");

  // An accepted audio word keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == cve_pkg::OP_AUDIO |=> in_stall)
    else $error("audio word did not start processing");

  // A new result only follows a busy period.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without processing");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind channel_vocoder_engine cve_checker u_cve_checker (.*);

/* test/channel_vocoder_engine_tb.sv */
// ----------------------------------------------------------------------------
// channel_vocoder_engine_tb
// Self-checking bench for the channel vocoder engine. Table writes and audio
// words are queued, driven with random gaps and predicted bit for bit as they
// are accepted; each left/right result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module channel_vocoder_engine_tb;
  import cve_pkg::*;

  localparam int NB         = BANDS_DEF;
  localparam int DRAIN_WAIT = 64;
  localparam int LIMIT      = 150000;
  localparam int LONG_HOLD  = 20000;

  typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] right;
  } mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = OP_AUDIO;
  logic signed [23:0] in_carrier_sample = '0;
  logic signed [23:0] in_modulator_sample = '0;
  logic [4:0]         in_band = '0;
  logic [3:0]         in_coef_select = '0;
  logic signed [23:0] in_coef_value = '0;
  logic [31:0]        in_route_mask = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_left_out;
  logic signed [31:0] out_right_out;
  logic               cfg_wr_en = 1'b0;
  logic [1:0]         cfg_index = CFG_BYPASS;
  logic [15:0]        cfg_data = '0;

  channel_vocoder_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_carrier_sample(in_carrier_sample),
    .in_modulator_sample(in_modulator_sample), .in_band(in_band),
    .in_coef_select(in_coef_select), .in_coef_value(in_coef_value),
    .in_route_mask(in_route_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Bench state shared between processes.
  item_t pending_words[$];
  mix_t  expected_mix[$];
  int    mismatches = 0;
  int    audio_seen = 0;
  int    writes_seen = 0;
  int    results_seen = 0;
  bit    no_idle = 1'b0;
  int    hold_asked = 0;
  int    hold_done = 0;

  // Predictor copy of registers and datapath state.
  bit          p_bypass;
  longint      p_cgain, p_mgain;
  longint      hist[2][2];        // [carrier/modulator][age]
  longint      taps[2][NB][2];    // [carrier/modulator][band][y1,y2]
  longint      env[NB];
  longint      coefs[NB][NSEL];
  logic [31:0] routes[NB];

  function automatic longint sat_to(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint sx24(logic [23:0] v);
    return longint'({{40{v[23]}}, v});
  endfunction

  // One bandpass section; updates its taps and returns the new output.
  function automatic longint bandpass(int bank, int k, longint x0, longint x2,
                                      longint a1, longint a2, longint b);
    longint t, y;
    t = (x0 - x2) - ((a2 * taps[bank][k][0]) >>> 21) - ((b * taps[bank][k][1]) >>> 21);
    y = sat_to((a1 * t) >>> 21, 32);
    taps[bank][k][1] = taps[bank][k][0];
    taps[bank][k][0] = y;
    return y;
  endfunction

  // Apply one accepted word; returns 1 and the stereo sample for audio words.
  function automatic bit vocode_word(item_t w, output mix_t m);
    longint gc, gm, xc, xm, ym, r, f, p, accl, accr;
    longint yc[NB];
    m.left = '0;
    m.right = '0;
    if (w.operation == OP_COEF) begin
      if (w.coef_select < NSEL) coefs[w.band][w.coef_select] = sx24(w.coef_value);
      return 1'b0;
    end
    if (w.operation == OP_ROUTE) begin
      routes[w.band] = w.route_mask;
      return 1'b0;
    end
    if (w.operation != OP_AUDIO) return 1'b0;
    gc = (sx24(w.carrier_sample) * p_cgain) >>> 12;
    gm = (sx24(w.modulator_sample) * p_mgain) >>> 12;
    xc = sat_to(gc, 24);
    xm = sat_to(gm, 24);
    for (int i = 0; i < NB; i++) begin
      yc[i] = bandpass(0, i, xc, hist[0][1], coefs[i][0], coefs[i][1], coefs[i][2]);
      ym = bandpass(1, i, xm, hist[1][1], coefs[i][3], coefs[i][4], coefs[i][5]);
      r = sat_to(ym < 0 ? -ym : ym, 32);
      f = env[i] < r ? coefs[i][6] : coefs[i][7];
      env[i] = sat_to((((longint'(1) <<< 21) - f) * r + f * env[i]) >>> 21, 32);
    end
    hist[0][1] = hist[0][0];
    hist[0][0] = xc;
    hist[1][1] = hist[1][0];
    hist[1][0] = xm;
    accl = 0;
    accr = 0;
    if (p_bypass) begin
      accl = gc;
      accr = gm;
    end else begin
      for (int i = 0; i < NB; i++) begin
        for (int j = 0; j < NB; j++) begin
          if (routes[i][j]) begin
            p = (yc[j] * env[i]) >>> 23;
            accl += (p * coefs[i][8]) >>> 21;
            accr += (p * coefs[i][9]) >>> 21;
          end
        end
      end
    end
    m.left = 32'(sat_to(accl, 32));
    m.right = 32'(sat_to(accr, 32));
    return 1'b1;
  endfunction

  // Idle length: mostly none, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Driver: offers queued words and predicts each one as it is accepted.
  int  tx_gap = 0;
  bit  tx_take;
  always @(posedge clk) begin
    mix_t m;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_take = in_valid && !in_stall;
      if (tx_take) begin
        if (vocode_word({in_operation, in_carrier_sample, in_modulator_sample, in_band,
                         in_coef_select, in_coef_value, in_route_mask}, m)) begin
          expected_mix.push_back(m);
          audio_seen++;
        end else begin
          writes_seen++;
        end
      end
      if (!in_valid || tx_take) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          item_t w;
          w = pending_words.pop_front();
          in_operation <= w.operation;
          in_carrier_sample <= w.carrier_sample;
          in_modulator_sample <= w.modulator_sample;
          in_band <= w.band;
          in_coef_select <= w.coef_select;
          in_coef_value <= w.coef_value;
          in_route_mask <= w.route_mask;
          in_valid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, one long hold on request, result checks.
  int rx_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    mix_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_mix.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: left %0d right %0d", out_left_out, out_right_out);
        end else begin
          e = expected_mix.pop_front();
          if (e.left !== out_left_out || e.right !== out_right_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected left %0d right %0d, got left %0d right %0d",
                       e.left, e.right, out_left_out, out_right_out);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_asked != hold_done) begin
        hold_done <= hold_asked;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else begin
        rx_gap <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts busy cycles in which neither channel moves a word.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (in_valid || pending_words.size() > 0 || expected_mix.size() > 0) begin
      quiet <= quiet + 1;
      if (quiet >= LIMIT) begin
        $display("FAIL channel_vocoder_engine");
        $finish;
      end
    end
  end

  // Word builders.
  function automatic item_t audio_word(logic [23:0] c, logic [23:0] m);
    item_t w;
    w = '0;
    w.operation = OP_AUDIO;
    w.carrier_sample = c;
    w.modulator_sample = m;
    w.band = 5'($urandom);
    w.coef_select = 4'($urandom);
    w.coef_value = 24'($urandom);
    w.route_mask = $urandom;
    return w;
  endfunction

  function automatic item_t coef_word(int k, logic [3:0] sel, logic [23:0] v);
    item_t w;
    w = audio_word(24'($urandom), 24'($urandom));
    w.operation = OP_COEF;
    w.band = 5'(k);
    w.coef_select = sel;
    w.coef_value = v;
    return w;
  endfunction

  function automatic item_t route_word(int k, logic [31:0] mask);
    item_t w;
    w = audio_word(24'($urandom), 24'($urandom));
    w.operation = OP_ROUTE;
    w.band = 5'(k);
    w.route_mask = mask;
    return w;
  endfunction

  // Plausible coefficient for a selector, so the filters mostly stay stable.
  function automatic logic [23:0] tame_coef(logic [3:0] sel);
    case (sel)
      SEL_CA1, SEL_MA1:      return 24'($urandom_range(0, 1 << 20)) - 24'(1 << 18);
      SEL_CA2, SEL_MA2:      return 24'($urandom_range(0, 1 << 22)) - 24'(1 << 21);
      SEL_CB, SEL_MB:        return 24'($urandom_range(0, 1 << 21));
      SEL_ATTACK, SEL_RELEASE: return 24'($urandom_range(0, 1 << 21));
      default:               return 24'($urandom_range(0, 1 << 22)) - 24'(1 << 21);
    endcase
  endfunction

  // Routing mask: usually a few bits, sometimes random or full.
  function automatic logic [31:0] pick_mask();
    int r;
    logic [31:0] mk;
    r = $urandom_range(99);
    if (r < 10) return $urandom;
    if (r < 13) return '1;
    mk = '0;
    repeat ($urandom_range(0, 3)) mk[$urandom_range(NB - 1)] = 1'b1;
    return mk;
  endfunction

  function automatic logic [23:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 24'h7F_FFFF;
    if (r < 10) return 24'h80_0000;
    if (r < 40) return 24'($urandom_range(0, 1 << 16)) - 24'(1 << 15);
    return 24'($urandom);
  endfunction

  function automatic item_t random_word();
    int r;
    logic [3:0] sel;
    r = $urandom_range(99);
    if (r < 62) return audio_word(pick_sample(), pick_sample());
    if (r < 82) begin
      sel = 4'($urandom_range(0, NSEL - 1));
      return coef_word($urandom_range(NB - 1), sel,
                       $urandom_range(3) == 0 ? 24'($urandom) : tame_coef(sel));
    end
    if (r < 92) return route_word($urandom_range(NB - 1), pick_mask());
    if (r < 96) return coef_word($urandom_range(NB - 1), 4'($urandom_range(NSEL, 15)),
                                 24'($urandom));
    begin
      item_t w;
      w = audio_word(24'($urandom), 24'($urandom));
      w.operation = 2'b11;
      return w;
    end
  endfunction

  // Wait until every queued word is taken and every result has come back.
  // The check runs mid-cycle so that the driver's updates have settled.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_mix.size() > 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_BYPASS) p_bypass = val[0];
    else if (idx == CFG_CGAIN) p_cgain = longint'(val);
    else p_mgain = longint'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_words.push_back(random_word());
    drain();
  endtask

  initial begin
    p_bypass = 1'b0;
    p_cgain = 4096;
    p_mgain = 4096;
    hist = '{default: 0};
    taps = '{default: 0};
    env = '{default: 0};
    coefs = '{default: 0};
    routes = '{default: 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Load every coefficient before any audio, plus sparse routing rows.
    no_idle = 1'b1;
    for (int k = 0; k < NB; k++)
      for (int s = 0; s < NSEL; s++)
        pending_words.push_back(coef_word(k, 4'(s), tame_coef(4'(s))));
    for (int k = 0; k < NB; k++) pending_words.push_back(route_word(k, pick_mask()));
    drain();
    no_idle = 1'b0;

    // Directed: sample extremes, full and empty rows, ignored words, odd factors.
    write_reg(CFG_BYPASS, 16'd0);
    write_reg(CFG_CGAIN, 16'd4096);
    write_reg(CFG_MGAIN, 16'd4096);
    pending_words.push_back(audio_word(24'h7F_FFFF, 24'h80_0000));
    pending_words.push_back(audio_word(24'h80_0000, 24'h7F_FFFF));
    pending_words.push_back(audio_word(24'h00_0000, 24'h00_0000));
    pending_words.push_back(route_word(0, '1));
    pending_words.push_back(route_word(31, 32'h8000_0001));
    pending_words.push_back(coef_word(0, SEL_ATTACK, 24'h7F_FFFF));
    pending_words.push_back(coef_word(31, SEL_RELEASE, 24'h80_0000));
    pending_words.push_back(coef_word(0, SEL_LEFT, 24'h7F_FFFF));
    pending_words.push_back(coef_word(0, SEL_RIGHT, 24'h80_0000));
    pending_words.push_back(coef_word(5, 4'd15, 24'h55_AAAA));
    pending_words.push_back(coef_word(6, 4'd10, 24'hAA_5555));
    begin
      item_t w;
      w = audio_word(24'h12_3456, 24'h65_4321);
      w.operation = 2'b11;
      pending_words.push_back(w);
    end
    pending_words.push_back(audio_word(24'h7F_FFFF, 24'h7F_FFFF));
    pending_words.push_back(audio_word(24'h80_0000, 24'h80_0000));
    pending_words.push_back(route_word(0, 32'h0000_0000));
    pending_words.push_back(audio_word(24'h40_0000, 24'hC0_0000));
    drain();

    // Bypass at high gain: gained samples exceed the filter range.
    write_reg(CFG_BYPASS, 16'd1);
    write_reg(CFG_CGAIN, 16'd40960);
    write_reg(CFG_MGAIN, 16'd40960);
    pending_words.push_back(audio_word(24'h7F_FFFF, 24'h80_0000));
    pending_words.push_back(audio_word(24'h80_0000, 24'h7F_FFFF));
    random_phase(25);

    // Mixing with uneven gains; the receiver holds off for a long stretch.
    write_reg(CFG_BYPASS, 16'd0);
    write_reg(CFG_CGAIN, 16'd40960);
    write_reg(CFG_MGAIN, 16'd4096);
    hold_asked++;
    random_phase(40);

    // Random gains, then a run with no idling at all.
    write_reg(CFG_CGAIN, 16'($urandom_range(4096, 40960)));
    write_reg(CFG_MGAIN, 16'($urandom_range(4096, 40960)));
    no_idle = 1'b1;
    random_phase(25);
    no_idle = 1'b0;
    write_reg(CFG_BYPASS, 16'd1);
    random_phase(15);
    write_reg(CFG_BYPASS, 16'd0);
    write_reg(CFG_CGAIN, 16'd4096);
    write_reg(CFG_MGAIN, 16'd40960);
    random_phase(35);

    $display("Covered %0d audio words and %0d table or ignored words, %0d results checked,",
             audio_seen, writes_seen, results_seen);
    $display("across bypass and mix modes with gain extremes and back-pressure.");
    if (mismatches == 0) begin
      $display("PASS channel_vocoder_engine");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL channel_vocoder_engine");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/cve_pkg.sv
rtl/core/cve_mul.sv
rtl/core/cve_coef_ram.sv
rtl/core/cve_core.sv
rtl/core/channel_vocoder_engine.sv
rtl/core/cve_checker.sv
test/channel_vocoder_engine_tb.sv
